// ----- design/skl_pkg.sv -----
// ---------------------------------------------------------------------------
// skl_pkg
// Shared types, sizes and command codes for the sorted key list.
// ---------------------------------------------------------------------------
package skl_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int KEY_BITS  = 32;
    localparam int ID_BITS   = 4;
    localparam int ID_COUNT  = 1 << ID_BITS;
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Status codes
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_IGNORED = 1'b1;

    // One list entry
    typedef struct packed {
        logic                valid;
        logic [ID_BITS-1:0]  id;
        logic [KEY_BITS-1:0] key;
    } t_slot;

    // Per-cell move controls, at most one set in a cycle
    typedef struct packed {
        logic take_left;
        logic load_new;
        logic take_right;
    } t_cell_ctrl;

    // Set every bit at or above the lowest set bit
    function automatic logic [MAX_ITEMS-1:0] prefix_or(input logic [MAX_ITEMS-1:0] v);
        logic [MAX_ITEMS-1:0] m;
        m = v;
        for (int s = 1; s < MAX_ITEMS; s = s * 2) begin
            m = m | (m << s);
        end
        return m;
    endfunction

endpackage

// ----- design/skl_if.sv -----
// ---------------------------------------------------------------------------
// skl_if
// Valid/ready channels carrying list commands and list results.
// ---------------------------------------------------------------------------
interface skl_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [skl_pkg::ID_BITS-1:0]  item_id;
    logic [31:0]                  key;

    modport source (output valid, command, item_id, key, input ready);
    modport sink   (input valid, command, item_id, key, output ready);
endinterface

interface skl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic                          head_valid;
    logic [skl_pkg::ID_BITS-1:0]   head_id;
    logic [31:0]                   head_key;
    logic [skl_pkg::CNT_BITS-1:0]  count;

    modport source (output valid, status, head_valid, head_id, head_key, count, input ready);
    modport sink   (input valid, status, head_valid, head_id, head_key, count, output ready);
endinterface

// ----- design/skl_cell.sv -----
// ---------------------------------------------------------------------------
// skl_cell
// One slot of the list: holds an entry, compares it against the incoming
// item and shifts from either neighbour or loads the new entry.
// ---------------------------------------------------------------------------
module skl_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  skl_pkg::t_cell_ctrl          i_ctrl,
    input  skl_pkg::t_slot               i_left,
    input  skl_pkg::t_slot               i_right,
    input  skl_pkg::t_slot               i_new,
    input  logic                         i_append,
    output skl_pkg::t_slot               o_slot,
    output skl_pkg::t_slot               o_next,
    output logic                         o_gt,
    output logic                         o_match
);

    skl_pkg::t_slot r_slot;
    skl_pkg::t_slot n_slot;

    // Flag an insert point: empty slot, or, unless appending, a key above the new one
    assign o_gt    = !r_slot.valid || (!i_append && (r_slot.key > i_new.key));
    assign o_match = r_slot.valid && (r_slot.id == i_new.id);

    // Select the next content
    always_comb begin
        n_slot = r_slot;
        if (i_ctrl.take_left) begin
            n_slot = i_left;
        end else if (i_ctrl.load_new) begin
            n_slot = i_new;
        end else if (i_ctrl.take_right) begin
            n_slot = i_right;
        end
    end

    // Hold the entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;
    assign o_next = n_slot;

endmodule

// ----- design/sorted_key_list_top.sv -----
// ---------------------------------------------------------------------------
// sorted_key_list_top
// Ordered list of item ids with keys, built as a row of slot cells.
// An accepted item's result is in the output register in the next cycle.
// Throughput: one item per cycle unless o_out stalls; every slot compares and shifts in parallel.
// Reset: synchronous, active low; empties the list and the result register.
// ---------------------------------------------------------------------------
module sorted_key_list_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    skl_in_if.sink        i_in,
    skl_out_if.source     o_out
);

    localparam int N = skl_pkg::MAX_ITEMS;

    skl_pkg::t_slot       w_slot [N];
    skl_pkg::t_slot       w_next [N];
    skl_pkg::t_cell_ctrl  w_ctrl [N];
    logic [N-1:0]         w_gt;
    logic [N-1:0]         w_match;
    logic [N-1:0]         w_after;
    logic [N-1:0]         w_rm;

    logic [skl_pkg::ID_COUNT-1:0] r_member;
    logic [skl_pkg::CNT_BITS-1:0] r_count;
    logic [skl_pkg::CNT_BITS-1:0] n_count;

    logic                          r_out_valid;
    logic                          r_status;
    logic                          r_head_valid;
    logic [skl_pkg::ID_BITS-1:0]   r_head_id;
    logic [31:0]                   r_head_key;
    logic [skl_pkg::CNT_BITS-1:0]  r_out_count;

    logic            w_accept;
    logic            w_add;
    logic            w_rem;
    logic            w_listed;
    logic            w_full;
    logic            w_ignored;
    logic            w_do_add;
    logic            w_do_rem;
    skl_pkg::t_slot  w_new;
    skl_pkg::t_slot  w_empty;

    // Accept while the result register is free or being drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Decode the command
    assign w_add     = (i_in.command == skl_pkg::CMD_INSERT) ||
                       (i_in.command == skl_pkg::CMD_APPEND);
    assign w_rem     = (i_in.command == skl_pkg::CMD_REMOVE);
    assign w_listed  = r_member[i_in.item_id];
    assign w_full    = (r_count == skl_pkg::CNT_BITS'(N));
    assign w_ignored = (w_add && (w_listed || w_full)) || (w_rem && !w_listed);
    assign w_do_add  = w_accept && w_add && !w_listed && !w_full;
    assign w_do_rem  = w_accept && w_rem && w_listed;

    assign w_new.valid = 1'b1;
    assign w_new.id    = i_in.item_id;
    assign w_new.key   = i_in.key[skl_pkg::KEY_BITS-1:0];
    assign w_empty     = '0;

    // Locate the insert point and the entry to drop
    assign w_after = skl_pkg::prefix_or(w_gt);
    assign w_rm    = skl_pkg::prefix_or(w_match);

    // Build the row of cells
    for (genvar g = 0; g < N; g++) begin : g_cell
        logic after_prev;
        if (g == 0) begin : g_first
            assign after_prev = 1'b0;
        end else begin : g_rest
            assign after_prev = w_after[g-1];
        end

        assign w_ctrl[g].take_left  = w_do_add && after_prev;
        assign w_ctrl[g].load_new   = w_do_add && w_after[g] && !after_prev;
        assign w_ctrl[g].take_right = w_do_rem && w_rm[g];

        skl_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl[g]),
            .i_left   ((g == 0) ? w_empty : w_slot[(g == 0) ? 0 : g-1]),
            .i_right  ((g == N-1) ? w_empty : w_slot[(g == N-1) ? g : g+1]),
            .i_new    (w_new),
            .i_append (i_in.command == skl_pkg::CMD_APPEND),
            .o_slot   (w_slot[g]),
            .o_next   (w_next[g]),
            .o_gt     (w_gt[g]),
            .o_match  (w_match[g])
        );
    end

    // Advance the entry count
    always_comb begin
        n_count = r_count;
        if (w_do_add) begin
            n_count = r_count + skl_pkg::CNT_BITS'(1);
        end else if (w_do_rem) begin
            n_count = r_count - skl_pkg::CNT_BITS'(1);
        end
    end

    // Hold membership, count and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_do_add) begin
                r_member[i_in.item_id] <= 1'b1;
            end else if (w_do_rem) begin
                r_member[i_in.item_id] <= 1'b0;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the head as it stands after the operation
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= w_ignored ? skl_pkg::ST_IGNORED : skl_pkg::ST_DONE;
            r_head_valid <= w_next[0].valid;
            r_head_id    <= w_next[0].valid ? w_next[0].id : '0;
            r_head_key   <= w_next[0].valid ? 32'(w_next[0].key) : '0;
            r_out_count  <= n_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.head_valid = r_head_valid;
    assign o_out.head_id    = r_head_id;
    assign o_out.head_key   = r_head_key;
    assign o_out.count      = r_out_count;

endmodule
